// ===== rtl/mse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// shared constants, widths and control types for the smooth escape pixel block
// ----------------------------------------------------------------------------
package mse_pkg;

   // image and iteration limits
   localparam int WIDTH    = 320;
   localparam int HEIGHT   = 256;
   localparam int MAX_ITER = 500;

   // field widths
   localparam int CFG_W = 18;
   localparam int COL_W = 9;
   localparam int ROW_W = 8;
   localparam int OUT_W = 16;

   localparam int QBITS        = 14;
   localparam int ESCAPE_LIMIT = 4 << QBITS;
   localparam logic [OUT_W-1:0] INSIDE_CODE = 16'hFFFF;

   // window edge difference and constant reciprocals for the steps
   // magnitude * ceil(2^shift / dim) >> shift is exact for magnitudes below 2^DIFF_W
   localparam int DIFF_W  = CFG_W + 1;
   localparam int RECIP_W = DIFF_W + 1;
   localparam int PROD_W  = DIFF_W + RECIP_W;
   localparam int SHIFT_X = DIFF_W + $clog2(WIDTH);
   localparam int SHIFT_Y = DIFF_W + $clog2(HEIGHT);
   localparam logic [RECIP_W-1:0] RECIP_X =
      RECIP_W'(((longint'(1) << SHIFT_X) + longint'(WIDTH - 1)) / longint'(WIDTH));
   localparam logic [RECIP_W-1:0] RECIP_Y =
      RECIP_W'(((longint'(1) << SHIFT_Y) + longint'(HEIGHT - 1)) / longint'(HEIGHT));

   // largest step and coordinate magnitudes
   localparam int DX_MAX = (1 << CFG_W) / WIDTH;
   localparam int DY_MAX = (1 << CFG_W) / HEIGHT;
   localparam int CR_MAX = (1 << (CFG_W - 1)) + ((1 << COL_W) - 1) * DX_MAX + DX_MAX;
   localparam int CI_MAX = (1 << (CFG_W - 1)) + ((1 << ROW_W) - 1) * DY_MAX + DY_MAX;
   localparam int C_MAX  = (CR_MAX > CI_MAX) ? CR_MAX : CI_MAX;
   localparam int CW     = $clog2(C_MAX + 1) + 1;

   // z stays bounded by |c| plus twice the escape radius squared
   localparam int Z_MAX = C_MAX + 2 * ESCAPE_LIMIT;
   localparam int ZW    = $clog2(Z_MAX + 1) + 1;
   localparam int PW    = 2 * ZW;
   localparam int MW    = PW - QBITS;

   // scoring
   localparam int ITER_W       = $clog2(MAX_ITER + 1);
   localparam int SCORE_W      = $clog2(MAX_ITER * 64);
   localparam int INSIDE_SCORE = MAX_ITER * 64 - 1;
   localparam int SUM_W        = SCORE_W + 2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_REAL   = 2'd0,
      CSR_TOP_IMAG    = 2'd1,
      CSR_RIGHT_REAL  = 2'd2,
      CSR_BOTTOM_IMAG = 2'd3
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic       base_load;
      logic       sample_load;
      logic       iter_step;
      logic       norm_step;
      logic       score_add;
      logic       result_load;
      logic [1:0] sample;
   } mse_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
      logic escaped;
      logic iter_done;
      logic norm_done;
   } mse_status_type;

endpackage
`default_nettype wire

// ===== rtl/mse_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_div
// pixel step divider: magnitude times a constant reciprocal, truncates toward zero
// ----------------------------------------------------------------------------
module mse_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [mse_pkg::DIFF_W-1:0]  dx_num,
   input  wire logic signed [mse_pkg::DIFF_W-1:0]  dy_num,
   output logic                                    done,
   output logic signed [mse_pkg::DIFF_W-1:0]       dx,
   output logic signed [mse_pkg::DIFF_W-1:0]       dy
);
   import mse_pkg::*;

   logic                running_ff;
   logic                done_ff;
   logic                neg_x_ff;
   logic                neg_y_ff;
   logic [DIFF_W-1:0]   mag_x_ff;
   logic [DIFF_W-1:0]   mag_y_ff;
   logic [DIFF_W-1:0]   quo_x_ff;
   logic [DIFF_W-1:0]   quo_y_ff;

   logic [PROD_W-1:0]   prod_x;
   logic [PROD_W-1:0]   prod_y;
   logic [PROD_W-1:0]   quo_x_full;
   logic [PROD_W-1:0]   quo_y_full;

   assign prod_x     = {{RECIP_W{1'b0}}, mag_x_ff} * {{DIFF_W{1'b0}}, RECIP_X};
   assign prod_y     = {{RECIP_W{1'b0}}, mag_y_ff} * {{DIFF_W{1'b0}}, RECIP_Y};
   assign quo_x_full = prod_x >> SHIFT_X;
   assign quo_y_full = prod_y >> SHIFT_Y;

   // magnitudes on start, scaled quotients in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (start) begin
         running_ff <= 1'b1;
         done_ff    <= 1'b0;
      end else if (running_ff) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_x_ff <= dx_num[DIFF_W-1];
         neg_y_ff <= dy_num[DIFF_W-1];
         mag_x_ff <= dx_num[DIFF_W-1] ? DIFF_W'(-dx_num) : DIFF_W'(dx_num);
         mag_y_ff <= dy_num[DIFF_W-1] ? DIFF_W'(-dy_num) : DIFF_W'(dy_num);
      end else if (running_ff) begin
         quo_x_ff <= quo_x_full[DIFF_W-1:0];
         quo_y_ff <= quo_y_full[DIFF_W-1:0];
      end
   end

   assign done = done_ff;
   assign dx   = neg_x_ff ? -$signed(quo_x_ff) : $signed(quo_x_ff);
   assign dy   = neg_y_ff ? -$signed(quo_y_ff) : $signed(quo_y_ff);

endmodule
`default_nettype wire

// ===== rtl/mse_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_dp
// datapath: window registers, step dividers, escape iteration and scoring
// ----------------------------------------------------------------------------
module mse_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [mse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mse_pkg::CFG_W-1:0]       csr_write_data,
   input  wire logic [mse_pkg::COL_W-1:0]       req_column,
   input  wire logic [mse_pkg::ROW_W-1:0]       req_row,
   input  wire mse_pkg::mse_cmd_type            cmd,
   output mse_pkg::mse_status_type              status,
   output logic [mse_pkg::OUT_W-1:0]            smooth_value
);
   import mse_pkg::*;

   // window registers
   logic signed [CFG_W-1:0] left_real_ff;
   logic signed [CFG_W-1:0] top_imag_ff;
   logic signed [CFG_W-1:0] right_real_ff;
   logic signed [CFG_W-1:0] bottom_imag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_real_ff   <= CFG_W'(-819);
         top_imag_ff    <= CFG_W'(10403);
         right_real_ff  <= CFG_W'(491);
         bottom_imag_ff <= CFG_W'(11386);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LEFT_REAL:   left_real_ff   <= csr_write_data;
            CSR_TOP_IMAG:    top_imag_ff    <= csr_write_data;
            CSR_RIGHT_REAL:  right_real_ff  <= csr_write_data;
            CSR_BOTTOM_IMAG: bottom_imag_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request capture
   logic [COL_W-1:0] column_ff;
   logic [ROW_W-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         column_ff <= req_column;
         row_ff    <= req_row;
      end
   end

   // pixel steps
   logic signed [DIFF_W-1:0] dx_num;
   logic signed [DIFF_W-1:0] dy_num;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic                     div_done;

   assign dx_num = right_real_ff - left_real_ff;
   assign dy_num = bottom_imag_ff - top_imag_ff;

   mse_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .dx_num (dx_num),
      .dy_num (dy_num),
      .done   (div_done),
      .dx     (dx),
      .dy     (dy)
   );

   // pixel origin and half steps
   logic signed [COL_W+DIFF_W+1:0] base_r_sum;
   logic signed [ROW_W+DIFF_W+1:0] base_i_sum;
   logic signed [CW-1:0]           base_r_ff;
   logic signed [CW-1:0]           base_i_ff;
   logic signed [DIFF_W-1:0]       hdx_ff;
   logic signed [DIFF_W-1:0]       hdy_ff;

   assign base_r_sum = $signed({1'b0, column_ff}) * dx + left_real_ff;
   assign base_i_sum = $signed({1'b0, row_ff}) * dy + top_imag_ff;

   always_ff @(posedge clock) begin
      if (cmd.base_load) begin
         base_r_ff <= base_r_sum[CW-1:0];
         base_i_ff <= base_i_sum[CW-1:0];
         hdx_ff    <= dx >>> 1;
         hdy_ff    <= dy >>> 1;
      end
   end

   // subsample point
   logic signed [DIFF_W-1:0] hdx_sel;
   logic signed [DIFF_W-1:0] hdy_sel;
   logic signed [CW:0]       c_r_sum;
   logic signed [CW:0]       c_i_sum;

   always_comb begin
      hdx_sel = hdx_ff;
      hdy_sel = hdy_ff;
      if (!cmd.sample[0]) hdx_sel = '0;
      if (!cmd.sample[1]) hdy_sel = '0;
   end

   assign c_r_sum = base_r_ff + hdx_sel;
   assign c_i_sum = base_i_ff + hdy_sel;

   // escape iteration
   logic signed [CW-1:0] c_r_ff;
   logic signed [CW-1:0] c_i_ff;
   logic signed [ZW-1:0] z_r_ff;
   logic signed [ZW-1:0] z_i_ff;
   logic [ITER_W-1:0]    iter_ff;
   logic [MW-1:0]        mag_ff;

   logic signed [PW-1:0] sq_r;
   logic signed [PW-1:0] sq_i;
   logic signed [PW-1:0] sq_x;
   logic signed [PW-1:0] zr2;
   logic signed [PW-1:0] zi2;
   logic signed [PW-1:0] zx;
   logic signed [PW-1:0] nzr_full;
   logic signed [PW-1:0] nzi_full;
   logic [MW-1:0]        mag;
   logic                 escaped;
   logic                 iter_done;

   assign sq_r = z_r_ff * z_r_ff;
   assign sq_i = z_i_ff * z_i_ff;
   assign sq_x = z_r_ff * z_i_ff;
   assign zr2  = sq_r >>> QBITS;
   assign zi2  = sq_i >>> QBITS;
   assign zx   = sq_x >>> QBITS;

   assign mag       = zr2[MW-1:0] + zi2[MW-1:0];
   assign escaped   = mag > MW'(ESCAPE_LIMIT);
   assign iter_done = iter_ff == ITER_W'(MAX_ITER);

   assign nzr_full = zr2 - zi2 + c_r_ff;
   assign nzi_full = (zx <<< 1) + c_i_ff;

   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         c_r_ff  <= c_r_sum[CW-1:0];
         c_i_ff  <= c_i_sum[CW-1:0];
         z_r_ff  <= '0;
         z_i_ff  <= '0;
         iter_ff <= '0;
      end else if (cmd.iter_step && !iter_done && !escaped) begin
         z_r_ff  <= nzr_full[ZW-1:0];
         z_i_ff  <= nzi_full[ZW-1:0];
         iter_ff <= iter_ff + 1'b1;
      end
   end

   // magnitude capture, then shift left until the leading one is on top
   always_ff @(posedge clock) begin
      if (cmd.iter_step) begin
         mag_ff <= mag;
      end else if (cmd.norm_step) begin
         mag_ff <= mag_ff << 1;
      end
   end

   // scoring
   logic [7:0]         frac8;
   logic [SCORE_W-1:0] score;
   logic [SUM_W-1:0]   sum_ff;
   logic               all_inside_ff;
   logic [OUT_W-1:0]   smooth_value_ff;

   assign frac8 = mag_ff[MW-2 -: 8];

   always_comb begin
      if (iter_done) begin
         score = SCORE_W'(INSIDE_SCORE);
      end else begin
         score = SCORE_W'({iter_ff, 6'b111111}) - SCORE_W'(frac8[7:2]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.base_load) begin
         sum_ff        <= '0;
         all_inside_ff <= 1'b1;
      end else if (cmd.score_add) begin
         sum_ff        <= sum_ff + SUM_W'(score);
         all_inside_ff <= all_inside_ff & iter_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         smooth_value_ff <= all_inside_ff ? INSIDE_CODE : OUT_W'(sum_ff[SUM_W-1:2]);
      end
   end

   assign smooth_value     = smooth_value_ff;
   assign status.div_done  = div_done;
   assign status.escaped   = escaped;
   assign status.iter_done = iter_done;
   assign status.norm_done = mag_ff[MW-1];

endmodule
`default_nettype wire

// ===== rtl/mse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ctrl
// sequencer: step division, four subsample iterations, scoring and result
// ----------------------------------------------------------------------------
module mse_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire mse_pkg::mse_status_type status,
   output logic                         busy,
   output logic                         rsp_strobe,
   output mse_pkg::mse_cmd_type         cmd
);
   import mse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_BASE,
      ST_LOAD,
      ST_ITER,
      ST_NORM,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] sample_ff;
   logic       busy_ff;
   logic       strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sample_ff <= '0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  busy_ff  <= 1'b1;
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (status.div_done) state_ff <= ST_BASE;
            end
            ST_BASE: begin
               sample_ff <= '0;
               state_ff  <= ST_LOAD;
            end
            ST_LOAD: begin
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               if (status.iter_done) begin
                  state_ff <= ST_ADD;
               end else if (status.escaped) begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (status.norm_done) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               if (sample_ff == 2'd3) begin
                  state_ff <= ST_OUT;
               end else begin
                  sample_ff <= sample_ff + 1'b1;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_OUT: begin
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: begin
               busy_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.sample      = sample_ff;
      cmd.capture     = (state_ff == ST_IDLE) && start;
      cmd.div_start   = state_ff == ST_DIV_GO;
      cmd.base_load   = state_ff == ST_BASE;
      cmd.sample_load = state_ff == ST_LOAD;
      cmd.iter_step   = state_ff == ST_ITER;
      cmd.norm_step   = (state_ff == ST_NORM) && !status.norm_done;
      cmd.score_add   = state_ff == ST_ADD;
      cmd.result_load = state_ff == ST_OUT;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

// ===== rtl/mandelbrot_smooth_escape_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_smooth_escape_pixel
// smooth escape-time score of one pixel, 2x2 supersampled, q14 fixed point
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   request   req_column, req_row                     start high while busy low
//   result    rsp_smooth_value                        rsp_strobe, one cycle
//   csr       csr_index, csr_write_data               csr_write_enable
//
// one request at a time; busy rises the cycle after start is taken
// per request: step division, then for each of the four subsamples a load,
//   the iterations, the leading-one shift for an escaped subsample and the add,
//   then the result register; the step division is a constant reciprocal multiply
// synchronous active-high reset restores the default window and idles the sequencer
// the result strobe lasts one cycle and cannot be held off by the receiver
//
module mandelbrot_smooth_escape_pixel (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [mse_pkg::COL_W-1:0]       req_column,
   input  wire logic [mse_pkg::ROW_W-1:0]       req_row,
   // result
   output logic                                 rsp_strobe,
   output logic [mse_pkg::OUT_W-1:0]            rsp_smooth_value,
   // window registers
   input  wire logic                            csr_write_enable,
   input  wire logic [mse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mse_pkg::CFG_W-1:0]       csr_write_data
);
   import mse_pkg::*;

   mse_cmd_type    cmd;
   mse_status_type status;

   // sequencer: division, per-subsample load / iterate / normalize / add
   mse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // arithmetic: window, steps, z iteration, scoring and result register
   mse_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_column       (req_column),
      .req_row          (req_row),
      .cmd              (cmd),
      .status           (status),
      .smooth_value     (rsp_smooth_value)
   );

endmodule
`default_nettype wire

// ===== sim/tb_mandelbrot_smooth_escape_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_smooth_escape_pixel
// self-checking bench for the supersampled smooth escape pixel scorer
// ----------------------------------------------------------------------------
// a class-based scoreboard keeps its own copy of the window registers and
// works out the smooth value of every accepted pixel request with exact 64-bit
// q14 arithmetic. results are matched in order against those predictions.
// the run walks through several windows: the reset view, the classic full
// view, both corner extremes, a reversed window, a zero-step window where
// every pixel is inside, and a few random windows.
// ----------------------------------------------------------------------------
module tb_mandelbrot_smooth_escape_pixel;
   import mse_pkg::*;

   // worst pixel: four slowest subsamples, plus sequencing overhead
   localparam int unsigned PIXEL_CYCLES  = 4 * (MAX_ITER + 14) + 6;
   localparam int unsigned MAX_GAP       = 400;
   localparam int unsigned REQUEST_BOUND = 400;
   localparam int unsigned CYCLE_LIMIT   = 4 * REQUEST_BOUND * (PIXEL_CYCLES + MAX_GAP);
   localparam int unsigned MAX_REPORTS   = 10;

   // ------------------------------------------------------------------------
   // scoreboard: window copy, smooth value prediction, in-order compare
   // ------------------------------------------------------------------------
   class smooth_value_checker;
      longint left_real;
      longint top_imag;
      longint right_real;
      longint bottom_imag;
      logic [OUT_W-1:0] expected_values[$];
      int unsigned requests;
      int unsigned results;
      int unsigned inside_results;
      int unsigned failures;

      function new();
         // power-up window of the block
         left_real   = -819;
         top_imag    = 10403;
         right_real  = 491;
         bottom_imag = 11386;
         requests       = 0;
         results        = 0;
         inside_results = 0;
         failures       = 0;
      endfunction

      function void set_window(csr_index_type idx, logic [CFG_W-1:0] value);
         longint coord;
         coord = longint'($signed(value));
         case (idx)
            CSR_LEFT_REAL:   left_real   = coord;
            CSR_TOP_IMAG:    top_imag    = coord;
            CSR_RIGHT_REAL:  right_real  = coord;
            CSR_BOTTOM_IMAG: bottom_imag = coord;
            default: ;
         endcase
      endfunction

      // score of one subsample; products are exact and floored by the shift
      function int unsigned escape_score(longint cr, longint ci, output bit in_set);
         longint zr, zi, zr2, zi2, next_zr, magnitude;
         int unsigned iter;
         int k;
         logic [7:0] frac;
         zr = 0;
         zi = 0;
         zr2 = 0;
         zi2 = 0;
         iter = 0;
         while (iter < MAX_ITER) begin
            zr2 = (zr * zr) >>> QBITS;
            zi2 = (zi * zi) >>> QBITS;
            if (zr2 + zi2 > ESCAPE_LIMIT)
               break;
            next_zr = zr2 - zi2 + cr;
            zi = 2 * ((zr * zi) >>> QBITS) + ci;
            zr = next_zr;
            iter++;
         end
         if (iter >= MAX_ITER) begin
            in_set = 1'b1;
            return MAX_ITER * 64 - 1;
         end
         in_set = 1'b0;
         // eight bits just below the leading one of |z|^2
         magnitude = zr2 + zi2;
         k = 0;
         while ((magnitude >> (k + 1)) != 0)
            k++;
         if (k >= 8)
            frac = 8'((magnitude >> (k - 8)) & 8'hFF);
         else
            frac = 8'((magnitude << (8 - k)) & 8'hFF);
         return iter * 64 + 63 - (frac >> 2);
      endfunction

      function logic [OUT_W-1:0] pixel_smooth_value(logic [COL_W-1:0] col,
                                                    logic [ROW_W-1:0] row);
         longint dx, dy, half_dx, half_dy, base_r, base_i, cr, ci;
         int unsigned total;
         int inside_count;
         bit in_set;
         // steps truncate toward zero, half steps round toward minus infinity
         dx = (right_real - left_real) / longint'(WIDTH);
         dy = (bottom_imag - top_imag) / longint'(HEIGHT);
         half_dx = dx >>> 1;
         half_dy = dy >>> 1;
         base_r = left_real + longint'(col) * dx;
         base_i = top_imag + longint'(row) * dy;
         total = 0;
         inside_count = 0;
         for (int s = 0; s < 4; s++) begin
            cr = base_r + (((s & 1) != 0) ? half_dx : 64'sd0);
            ci = base_i + (((s & 2) != 0) ? half_dy : 64'sd0);
            total += escape_score(cr, ci, in_set);
            if (in_set)
               inside_count++;
         end
         if (inside_count == 4)
            return INSIDE_CODE;
         return OUT_W'(total >> 2);
      endfunction

      function void note_request(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
         expected_values.push_back(pixel_smooth_value(col, row));
         requests++;
      endfunction

      function void check_result(logic [OUT_W-1:0] actual);
         logic [OUT_W-1:0] expected;
         results++;
         if (expected_values.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: smooth value %0d with no request outstanding", $realtime, actual);
            return;
         end
         expected = expected_values.pop_front();
         if (expected == INSIDE_CODE)
            inside_results++;
         if (actual !== expected) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: smooth value mismatch, expected %0d, got %0d",
                        $realtime, expected, actual);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block hookup, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [COL_W-1:0]    req_column       = '0;
   logic [ROW_W-1:0]    req_row          = '0;
   logic                rsp_strobe;
   logic [OUT_W-1:0]    rsp_smooth_value;
   logic                csr_write_enable = 1'b0;
   csr_index_type       csr_index        = CSR_LEFT_REAL;
   logic [CFG_W-1:0]    csr_write_data   = '0;

   smooth_value_checker scores;
   int unsigned         idle_percent;
   int unsigned         window_count;
   int unsigned         cycle_count;

   mandelbrot_smooth_escape_pixel i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_column       (req_column),
      .req_row          (req_row),
      .rsp_strobe       (rsp_strobe),
      .rsp_smooth_value (rsp_smooth_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // results are one-cycle strobes; sample the pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         scores.check_result(rsp_smooth_value);
   end

   // watchdog, sized from the slowest legal run several times over
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, scores.expected_values.size());
      $display("** mandelbrot_smooth_escape_pixel: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------

   // one pixel request; start may stay high straight into the next request
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      int unsigned gap;
      gap = 0;
      if (idle_percent != 0 && $urandom_range(99) < idle_percent)
         // mostly short gaps, sometimes long enough to land mid-pixel
         gap = ($urandom_range(3) == 0) ? $urandom_range(20, MAX_GAP) : $urandom_range(1, 6);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_column <= col;
      req_row    <= row;
      // taken at the first edge where busy was low
      do @(posedge clock); while (busy);
      scores.note_request(col, row);
   endtask

   // random pixels, mostly inside the image, some past its right edge
   task automatic send_random_pixels(input int unsigned count);
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0)
            col = COL_W'($urandom_range((1 << COL_W) - 1, WIDTH));
         else
            col = COL_W'($urandom_range(WIDTH - 1, 0));
         row = ROW_W'($urandom_range((1 << ROW_W) - 1, 0));
         send_pixel(col, row);
      end
   endtask

   // every request gets a result, so once nothing is owed and busy is low
   // the block is idle
   task automatic wait_idle();
      start <= 1'b0;
      while (scores.expected_values.size() != 0)
         @(posedge clock);
      do @(posedge clock); while (busy);
   endtask

   // csr writes go one per cycle; enable is dropped once, by the caller
   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      scores.set_window(idx, value);
   endtask

   task automatic program_window(input logic [CFG_W-1:0] left, input logic [CFG_W-1:0] top,
                                 input logic [CFG_W-1:0] right,
                                 input logic [CFG_W-1:0] bottom);
      wait_idle();
      write_csr(CSR_LEFT_REAL, left);
      write_csr(CSR_TOP_IMAG, top);
      write_csr(CSR_RIGHT_REAL, right);
      write_csr(CSR_BOTTOM_IMAG, bottom);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      window_count++;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      scores       = new();
      idle_percent = 20;
      window_count = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window: image corners, pixels past the right edge, mixed bits
      send_pixel(9'd0, 8'd0);
      send_pixel(COL_W'(WIDTH - 1), ROW_W'(HEIGHT - 1));
      send_pixel(9'd511, 8'd255);
      send_pixel(COL_W'(WIDTH), 8'd0);
      send_pixel(9'd0, ROW_W'(HEIGHT - 1));
      send_pixel(9'd511, 8'd0);
      send_pixel(COL_W'(WIDTH - 1), 8'd0);
      send_pixel(9'd0, 8'd128);
      send_pixel(9'd160, 8'd128);
      send_pixel(9'd255, 8'd170);
      send_pixel(9'd256, 8'd85);
      send_pixel(9'd170, 8'd1);
      send_random_pixels(50);

      // classic view -2..0.5 by -1.25..1.25; first half of the random pixels without any idling
      program_window(-18'sd32768, -18'sd20480, 18'sd8192, 18'sd20480);
      send_pixel(9'd200, 8'd128);   // c near -0.44, deep inside the cardioid
      send_pixel(9'd0, 8'd0);
      idle_percent = 0;
      send_random_pixels(40);
      idle_percent = 20;
      send_random_pixels(40);

      // widest window, imaginary axis reversed: most pixels escape almost at once
      program_window(-18'sd131072, 18'sd131071, 18'sd131071, -18'sd131072);
      send_pixel(9'd0, 8'd0);
      send_pixel(9'd511, 8'd255);
      send_random_pixels(30);

      // the opposite corners, real axis reversed
      program_window(18'sd131071, -18'sd131072, -18'sd131072, 18'sd131071);
      send_random_pixels(20);

      // zero step: every subsample sits on c = -0.25, so the pixel is inside
      program_window(-18'sd4096, 18'sd0, -18'sd4096, 18'sd0);
      send_pixel(9'd0, 8'd0);
      send_pixel(9'd511, 8'd255);
      send_pixel(9'd100, 8'd100);

      // both axes reversed over the classic view
      program_window(18'sd8192, 18'sd20480, -18'sd32768, -18'sd20480);
      send_random_pixels(60);

      // random windows, any 18-bit pattern on each edge
      for (int w = 0; w < 3; w++) begin
         program_window(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                        CFG_W'($urandom));
         send_random_pixels(20);
      end

      // drain, then watch a while longer for stray strobes
      wait_idle();
      repeat (64) @(posedge clock);

      $display("covered %0d pixel requests over %0d windows, %0d fully inside",
               scores.requests, window_count, scores.inside_results);
      $display("%0d results checked, %0d failures, %0d still owed",
               scores.results, scores.failures, scores.expected_values.size());
      if (scores.failures == 0 && scores.expected_values.size() == 0)
         $display("** mandelbrot_smooth_escape_pixel: PASSED **");
      else
         $display("** mandelbrot_smooth_escape_pixel: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mse_pkg.sv
rtl/mse_div.sv
rtl/mse_dp.sv
rtl/mse_ctrl.sv
rtl/mandelbrot_smooth_escape_pixel.sv
sim/tb_mandelbrot_smooth_escape_pixel.sv
